[rtl/hria_pkg.sv]
// Shared constants, types and command/status structs for the heart-rate interval averager.
`timescale 1ns / 1ps
package hria_pkg;

    // Ring of accepted whole rates.
    localparam int RING_ENTRIES = 4;
    localparam int RING_IDX_W   = (RING_ENTRIES > 1) ? $clog2(RING_ENTRIES) : 1;
    localparam int RING_TOTAL_W = 8 + RING_IDX_W;

    // 60000 ms per minute, scaled by 256 for Q16.8.
    localparam logic [23:0] RATE_NUMERATOR = 24'd15360000;
    localparam logic [31:0] MIN_INTERVAL   = 32'd273;
    localparam logic [31:0] MAX_INTERVAL   = 32'd2000;
    localparam logic [23:0] RATE_SATURATED = 24'hFFFFFF;
    localparam logic [15:0] COUNT_FULL     = 16'hFFFF;
    localparam logic [31:0] WINDOW_RESET   = 32'd60000;

    // Divider step counts for each of the two quotients.
    localparam logic [4:0] STEPS_RATE = 5'd24;
    localparam logic [4:0] STEPS_WIN  = 5'd16;

    // Item kinds carried in tuser bit 0.
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_WINDOW_RESET = 1'b1;

    typedef enum logic [1:0] {
        DIV_RATE,
        DIV_WIN
    } t_div_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_RATE_WAIT,
        ST_APPLY,
        ST_WIN_START,
        ST_WIN_WAIT,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic     load;
        logic     div_start;
        t_div_sel div_sel;
        logic     apply;
        logic     cap_win;
        logic     clr_win;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic beat_item;
        logic interval_zero;
        logic div_busy;
        logic count_zero;
        logic out_free;
    } t_dp_stat;

endpackage

[rtl/hria_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module hria_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[rtl/hria_div.sv]
// Serial restoring divider producing one quotient bit per cycle.
`timescale 1ns / 1ps
module hria_div
    import hria_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_rem_init,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    input  logic [4:0]  i_steps,
    output logic        o_busy,
    output logic [31:0] o_quotient
);

    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_den;
    logic [4:0]  r_cnt;
    logic [33:0] n_trial;

    // The dividend is left-aligned so its next bit is always r_quo[31];
    // quotient bits shift in at the bottom.
    assign n_trial = {1'b0, r_rem, r_quo[31]} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_steps;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem_init;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_cnt != '0) begin
            if (!n_trial[33]) begin
                r_rem <= n_trial[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= {r_rem[30:0], r_quo[31]};
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_quo;

endmodule

[rtl/hria_datapath.sv]
// Datapath: beat state, rate ring, window accumulators, divider and output register.
`timescale 1ns / 1ps
module hria_datapath
    import hria_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_mode,
    input  logic        i_beat,
    input  logic [31:0] i_now_ms,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [55:0] o_out_data
);

    // Item fields.
    logic        r_mode;
    logic        r_beat;
    logic [31:0] r_now;
    logic [31:0] r_interval;

    // Block state.
    logic [31:0]             r_window_len;
    logic [31:0]             r_last_beat;
    logic [31:0]             r_win_start;
    logic                    r_started;
    logic [RING_IDX_W-1:0]   r_ring_pos;
    logic [RING_TOTAL_W-1:0] r_ring_total;
    logic [RING_ENTRIES-1:0] r_ring_valid;
    logic [31:0]             r_win_sum;
    logic [15:0]             r_win_cnt;
    logic [23:0]             r_last_rate;
    logic                    r_accepted;
    logic [15:0]             r_win_avg;
    logic                    r_out_valid;
    logic [55:0]             r_out_data;

    // Divider hookup.
    logic [31:0] n_div_rem;
    logic [31:0] n_div_dividend;
    logic [31:0] n_div_divisor;
    logic [4:0]  n_div_steps;
    logic        div_busy;
    logic [31:0] div_quo;

    // Ring entry under the write pointer.
    logic [7:0]  ram_rdata;
    logic [7:0]  n_old_rate;
    logic [7:0]  n_whole;
    logic        n_in_range;
    logic        n_in_window;
    logic [31:0] n_elapsed;
    logic [RING_TOTAL_W-1:0] n_ring_quo;

    always_comb begin
        case (i_cmd.div_sel)
            DIV_RATE: begin
                n_div_rem      = '0;
                n_div_dividend = {RATE_NUMERATOR, 8'b0};
                n_div_divisor  = r_interval;
                n_div_steps    = STEPS_RATE;
            end
            default: begin
                // Every summed rate is below 2^16, so the mean fits 16 bits.
                n_div_rem      = {16'b0, r_win_sum[31:16]};
                n_div_dividend = {r_win_sum[15:0], 16'b0};
                n_div_divisor  = {16'b0, r_win_cnt};
                n_div_steps    = STEPS_WIN;
            end
        endcase
    end

    hria_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_rem_init (n_div_rem),
        .i_dividend (n_div_dividend),
        .i_divisor  (n_div_divisor),
        .i_steps    (n_div_steps),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    assign n_in_range  = (r_interval >= MIN_INTERVAL) && (r_interval <= MAX_INTERVAL);
    assign n_whole     = div_quo[15:8];
    assign n_old_rate  = r_ring_valid[r_ring_pos] ? ram_rdata : 8'd0;
    assign n_elapsed   = r_now - r_win_start;
    assign n_in_window = (n_elapsed <= r_window_len) && (r_win_cnt != COUNT_FULL);

    // The ring size is a power of two, so its mean is a plain shift of the total.
    // The total stays below RING_ENTRIES * 256, so the mean fits 8 bits.
    assign n_ring_quo  = r_ring_total / RING_TOTAL_W'(RING_ENTRIES);

    hria_ram #(
        .WIDTH (8),
        .DEPTH (RING_ENTRIES)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.apply && n_in_range),
        .i_waddr (r_ring_pos),
        .i_wdata (n_whole),
        .i_raddr (r_ring_pos),
        .o_rdata (ram_rdata)
    );

    // Item capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode     <= i_mode;
            r_beat     <= i_beat;
            r_now      <= i_now_ms;
            r_interval <= i_now_ms - r_last_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= WINDOW_RESET;
            r_last_beat  <= '0;
            r_win_start  <= '0;
            r_started    <= 1'b0;
            r_ring_pos   <= '0;
            r_ring_total <= '0;
            r_ring_valid <= '0;
            r_win_sum    <= '0;
            r_win_cnt    <= '0;
            r_last_rate  <= '0;
            r_accepted   <= 1'b0;
            r_win_avg    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_window_len <= i_cfg_wr_data;
            end
            if (i_cmd.load) begin
                r_accepted <= 1'b0;
                if (i_mode == MODE_WINDOW_RESET) begin
                    r_win_sum   <= '0;
                    r_win_cnt   <= '0;
                    r_win_start <= i_now_ms;
                    r_started   <= 1'b1;
                end else if (!r_started) begin
                    r_win_start <= i_now_ms;
                    r_started   <= 1'b1;
                end
            end
            if (i_cmd.apply) begin
                r_last_beat <= r_now;
                r_last_rate <= (r_interval == '0) ? RATE_SATURATED : div_quo[23:0];
                if (n_in_range) begin
                    r_accepted   <= 1'b1;
                    r_ring_total <= r_ring_total - RING_TOTAL_W'(n_old_rate)
                                    + RING_TOTAL_W'(n_whole);
                    r_ring_valid[r_ring_pos] <= 1'b1;
                    r_ring_pos <= (r_ring_pos == RING_IDX_W'(RING_ENTRIES - 1)) ?
                                  '0 : r_ring_pos + 1'b1;
                    if (n_in_window) begin
                        r_win_sum <= r_win_sum + {8'b0, div_quo[23:0]};
                        r_win_cnt <= r_win_cnt + 16'd1;
                    end
                end
            end
            if (i_cmd.cap_win) begin
                r_win_avg <= div_quo[15:0];
            end else if (i_cmd.clr_win) begin
                r_win_avg <= '0;
            end
        end
    end

    // Output register; a new item may be loaded in the cycle the old one is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {7'b0, r_win_avg, n_ring_quo[7:0], r_accepted, r_last_rate};
        end
    end

    assign o_stat.beat_item     = (r_mode == MODE_SAMPLE) && r_beat;
    assign o_stat.interval_zero = (r_interval == '0);
    assign o_stat.div_busy      = div_busy;
    assign o_stat.count_zero    = (r_win_cnt == '0);
    assign o_stat.out_free      = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[rtl/hria_ctrl.sv]
// Controller state machine sequencing the divisions and updates of one item.
`timescale 1ns / 1ps
module hria_ctrl
    import hria_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.div_sel = DIV_RATE;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!i_stat.beat_item) begin
                    n_state = ST_WIN_START;
                end else if (i_stat.interval_zero) begin
                    n_state = ST_APPLY;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_RATE;
                    n_state         = ST_RATE_WAIT;
                end
            end
            ST_RATE_WAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = ST_WIN_START;
            end
            ST_WIN_START: begin
                if (i_stat.count_zero) begin
                    o_cmd.clr_win = 1'b1;
                    n_state       = ST_FINISH;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_WIN;
                    n_state         = ST_WIN_WAIT;
                end
            end
            ST_WIN_WAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.cap_win = 1'b1;
                    n_state       = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/heart_rate_interval_averager.sv]
// Top level of the heart-rate interval averager: controller, datapath and checks.
//
// Usage: input items arrive on the s_axis channel. tdata carries the 32-bit millisecond
// timestamp; tuser bit 0 is the mode (0 sample, 1 window reset) and bit 1 the beat flag.
// Every input item produces exactly one result item on the m_axis channel, in order.
// A beat yields an instant rate of 60000/interval BPM in Q16.8; rates for intervals of
// 273 to 2000 ms enter a small ring of whole rates and, inside the window, the window
// sum and count. Each result carries the last rate, the accept flag, the ring mean and
// the window mean in Q8.8.
// The window length register is written through i_cfg_wr_en / i_cfg_wr_data; the
// user must write it only while the block is idle (unchecked); it resets to 60000 ms.
// Timing: one item is processed at a time, through a single serial divider that yields
// one quotient bit a cycle. After acceptance the controller runs the 24-step rate
// division when a beat has a nonzero interval, applies any beat, runs the 16-step
// window mean when the window is not empty, and then loads the result; the next item
// is accepted in the cycle after the result is loaded.
// The input accepts the next item as soon as the previous result sits in the output
// register, even if the receiver has not taken it yet; a stalled receiver holds the
// finished block only at the point where the next result would be loaded.
// Reset (synchronous, active low) clears the ring, the window and all timing state.
`timescale 1ns / 1ps
module heart_rate_interval_averager
    import hria_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: window length in milliseconds.
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    // Input item channel.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [31:0] now_ms
    input  logic [1:0]  i_s_axis_tuser,  // [0] mode, [1] beat
    // Result item channel.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata   // [23:0] instant_bpm, [24] rate_accepted,
                                         // [32:25] ring_average, [48:33] window_average,
                                         // [55:49] zero
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    hria_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hria_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_mode        (i_s_axis_tuser[0]),
        .i_beat        (i_s_axis_tuser[1]),
        .i_now_ms      (i_s_axis_tdata),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_out_data    (o_m_axis_tdata)
    );

    // A result is never loaded over one the receiver has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded while output register still held");

    // Only one item is in flight: after an acceptance the input closes.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted a second item while busy");

    // The divider is never restarted in the middle of a division.
    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |-> !stat.div_busy)
        else $error("divider started while busy");

    // A loaded result appears on the output in the next cycle.
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_m_axis_tvalid)
        else $error("loaded result not presented");

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the heart-rate interval averager stream block.
`timescale 1ns / 1ps
module tb;
    import hria_pkg::*;

    // Predictor constants, kept apart from the package so that a wrong package value shows up.
    localparam logic [31:0] BPM_Q88_NUMERATOR = 32'd15360000;
    localparam logic [31:0] SHORTEST_BEAT_MS  = 32'd273;
    localparam logic [31:0] LONGEST_BEAT_MS   = 32'd2000;
    localparam logic [23:0] BPM_SATURATED     = 24'hFFFFFF;
    localparam logic [31:0] BEAT_COUNT_FULL   = 32'd65535;
    localparam logic [31:0] DEFAULT_WINDOW_MS = 32'd60000;

    // Run control: cycles before a register write, drain after the end, and the stall limit.
    localparam int SETTLE_CYCLES = 64;
    localparam int TAIL_CYCLES   = 64;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 134;

    // One result item, unpacked from the output tdata.
    typedef struct packed {
        logic [23:0] bpm;
        logic        accepted;
        logic [7:0]  ring_avg;
        logic [15:0] win_avg;
    } beat_result_t;

    // One row of the directed table. When has_want is set, the typed-in result is checked;
    // otherwise the predictor supplies the expected result.
    typedef struct packed {
        logic         mode;
        logic [31:0]  now_ms;
        logic         beat;
        logic         has_want;
        beat_result_t want;
    } stim_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [31:0] i_cfg_wr_data = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;   // [31:0] now_ms
    logic [1:0]  i_s_axis_tuser = '0;   // [0] mode, [1] beat
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [55:0] o_m_axis_tdata;        // [23:0] instant_bpm, [24] rate_accepted,
                                        // [32:25] ring_average, [48:33] window_average

    // Percent of cycles in which the sender holds off and the receiver stalls.
    int send_idle_pct = 12;
    int recv_idle_pct = 61;

    int mismatch_count = 0;
    int quiet_cycles = 0;

    // Results that the predictor has worked out and the block has not yet delivered.
    beat_result_t pending_results[$];
    stim_row_t    directed_rows[$];

    // Predictor state: a private copy of everything the block remembers.
    logic [31:0] win_len_q    = DEFAULT_WINDOW_MS;
    logic [31:0] beat_time_q  = '0;
    logic [31:0] win_start_q  = '0;
    logic        win_open_q   = 1'b0;
    logic [7:0]  rate_hist[RING_ENTRIES];
    int          hist_pos     = 0;
    int          hist_total   = 0;
    logic [31:0] win_sum_q    = '0;
    logic [31:0] win_cnt_q    = '0;
    logic [23:0] rate_q       = '0;

    // Running timestamp for the random part, so that beats form plausible sequences.
    logic [31:0] clock_ms = '0;

    heart_rate_interval_averager dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Advances the predictor by one accepted item and returns the result it must cause.
    function automatic beat_result_t compute_beat_result(input logic mode,
                                                         input logic [31:0] now_ms,
                                                         input logic beat);
        beat_result_t res;
        logic [31:0]  interval;
        logic [31:0]  quotient;
        logic [7:0]   whole;
        logic         accepted;
        accepted = 1'b0;
        if (mode == MODE_WINDOW_RESET) begin
            // A window reset empties the window and restarts it here; the beat flag is ignored.
            win_sum_q   = '0;
            win_cnt_q   = '0;
            win_start_q = now_ms;
            win_open_q  = 1'b1;
        end else begin
            // The first sample after reset opens the window before its beat is handled.
            if (!win_open_q) begin
                win_start_q = now_ms;
                win_open_q  = 1'b1;
            end
            if (beat) begin
                interval    = now_ms - beat_time_q;
                beat_time_q = now_ms;
                if (interval == 32'd0) begin
                    rate_q = BPM_SATURATED;
                end else begin
                    quotient = BPM_Q88_NUMERATOR / interval;
                    rate_q   = quotient[23:0];
                end
                if (interval >= SHORTEST_BEAT_MS && interval <= LONGEST_BEAT_MS) begin
                    accepted = 1'b1;
                    whole = rate_q[15:8];
                    hist_total = hist_total - int'(rate_hist[hist_pos]) + int'(whole);
                    rate_hist[hist_pos] = whole;
                    hist_pos = (hist_pos + 1) % RING_ENTRIES;
                    if ((now_ms - win_start_q) <= win_len_q && win_cnt_q < BEAT_COUNT_FULL) begin
                        win_sum_q = win_sum_q + {8'd0, rate_q};
                        win_cnt_q = win_cnt_q + 32'd1;
                    end
                end
            end
        end
        res.bpm      = rate_q;
        res.accepted = accepted;
        quotient     = hist_total / RING_ENTRIES;
        res.ring_avg = quotient[7:0];
        if (win_cnt_q == 32'd0) begin
            res.win_avg = '0;
        end else begin
            quotient    = win_sum_q / win_cnt_q;
            res.win_avg = quotient[15:0];
        end
        return res;
    endfunction

    function automatic stim_row_t make_row(input logic mode, input logic [31:0] now_ms,
                                           input logic beat, input logic has_want,
                                           input logic [23:0] bpm, input logic accepted,
                                           input logic [7:0] ring_avg,
                                           input logic [15:0] win_avg);
        stim_row_t row;
        row.mode          = mode;
        row.now_ms        = now_ms;
        row.beat          = beat;
        row.has_want      = has_want;
        row.want.bpm      = bpm;
        row.want.accepted = accepted;
        row.want.ring_avg = ring_avg;
        row.want.win_avg  = win_avg;
        return row;
    endfunction

    // Offers one item on the input channel, holding off at random first, and returns once
    // the block has taken it. Called right after a rising edge.
    task automatic offer_item(input logic mode, input logic [31:0] now_ms, input logic beat,
                              output beat_result_t predicted);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= now_ms;
        i_s_axis_tuser  <= {beat, mode};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        // The item went in at this edge; the predictor moves on with it.
        predicted = compute_beat_result(mode, now_ms, beat);
    endtask

    // Random item: mostly samples and beats that follow on from the last beat, with edge
    // intervals, stray timestamps and window resets mixed in.
    task automatic send_random_item();
        beat_result_t predicted;
        logic [31:0]  interval;
        int           pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            clock_ms = clock_ms + $urandom_range(0, 600);
            offer_item(MODE_SAMPLE, clock_ms, 1'b0, predicted);
        end else if (pick < 85) begin
            case ($urandom_range(0, 9))
                0: begin
                    case ($urandom_range(0, 4))
                        0: interval = 32'd0;
                        1: interval = SHORTEST_BEAT_MS - 32'd1;
                        2: interval = SHORTEST_BEAT_MS;
                        3: interval = LONGEST_BEAT_MS;
                        default: interval = LONGEST_BEAT_MS + 32'd1;
                    endcase
                end
                1: interval = $urandom_range(0, 6000);
                default: interval = $urandom_range(SHORTEST_BEAT_MS, LONGEST_BEAT_MS);
            endcase
            clock_ms = beat_time_q + interval;
            offer_item(MODE_SAMPLE, clock_ms, 1'b1, predicted);
        end else if (pick < 93) begin
            offer_item(MODE_SAMPLE, $urandom, 1'($urandom_range(0, 1)), predicted);
        end else begin
            clock_ms = clock_ms + $urandom_range(0, 300);
            offer_item(MODE_WINDOW_RESET, clock_ms, 1'($urandom_range(0, 1)), predicted);
        end
        pending_results.push_back(predicted);
    endtask

    // Waits until every expected result has come back, so that the block is idle.
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window_length(input logic [31:0] length_ms);
        drain_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= length_ms;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        win_len_q = length_ms;
    endtask

    task automatic compare_field(input string label, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, label, want, got);
            mismatch_count++;
        end
    endtask

    // Receiver: stalls at random, checks every result item against the oldest expectation,
    // and counts the cycles in which neither channel moved an item.
    always @(posedge i_clk) begin
        beat_result_t got;
        beat_result_t want;
        logic         in_moved;
        logic         out_moved;
        in_moved  = i_s_axis_tvalid && o_s_axis_tready;
        out_moved = i_rst_n && o_m_axis_tvalid && i_m_axis_tready;
        if (out_moved) begin
            got.bpm      = o_m_axis_tdata[23:0];
            got.accepted = o_m_axis_tdata[24];
            got.ring_avg = o_m_axis_tdata[32:25];
            got.win_avg  = o_m_axis_tdata[48:33];
            if (pending_results.size() == 0) begin
                $display("%0t: result item with none expected, tdata %h", $time,
                         o_m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("instant_bpm", {8'd0, want.bpm}, {8'd0, got.bpm});
                compare_field("rate_accepted", {31'd0, want.accepted}, {31'd0, got.accepted});
                compare_field("ring_average", {24'd0, want.ring_avg}, {24'd0, got.ring_avg});
                compare_field("window_average", {16'd0, want.win_avg}, {16'd0, got.win_avg});
            end
        end
        quiet_cycles    <= (in_moved || out_moved) ? 0 : quiet_cycles + 1;
        i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog: a run in which nothing moves for too long has hung.
    initial begin
        @(posedge i_clk);
        while (quiet_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("[heart_rate_interval_averager] ERROR");
        $finish;
    end

    initial begin
        logic [31:0]  window_lengths[PHASES];
        beat_result_t predicted;
        stim_row_t    row;

        for (int i = 0; i < RING_ENTRIES; i++) rate_hist[i] = '0;

        // Window lengths for the random phases: the extremes, the reset value and a few others.
        window_lengths[0] = 32'd1;
        window_lengths[1] = 32'hFFFF_FFFF;
        window_lengths[2] = 32'd3000;
        window_lengths[3] = $urandom_range(500, 100000);
        window_lengths[4] = DEFAULT_WINDOW_MS;
        window_lengths[5] = $urandom;

        // Directed table, run with the reset window length of 60000 ms.
        // First sample after reset opens the window at 0 and reports all zeros.
        directed_rows.push_back(make_row(MODE_SAMPLE, 32'd0, 1'b0, 1'b1, 24'd0, 1'b0, 8'd0, 16'd0));
        // First beat at the reset beat time: zero interval saturates and is rejected.
        directed_rows.push_back(make_row(MODE_SAMPLE, 32'd0, 1'b1, 1'b1,
                                         24'hFFFFFF, 1'b0, 8'd0, 16'd0));
        // A 1000 ms interval is exactly 60 BPM; one ring entry of 60 over four slots.
        directed_rows.push_back(make_row(MODE_SAMPLE, 32'd1000, 1'b1, 1'b1,
                                         24'd15360, 1'b1, 8'd15, 16'd15360));
        // Shortest and longest accepted intervals, then one millisecond outside each.
        directed_rows.push_back(make_row(MODE_SAMPLE, 32'd1273, 1'b1, 1'b0, '0, '0, '0, '0));
        directed_rows.push_back(make_row(MODE_SAMPLE, 32'd3273, 1'b1, 1'b0, '0, '0, '0, '0));
        directed_rows.push_back(make_row(MODE_SAMPLE, 32'd3545, 1'b1, 1'b0, '0, '0, '0, '0));
        directed_rows.push_back(make_row(MODE_SAMPLE, 32'd5546, 1'b1, 1'b0, '0, '0, '0, '0));
        // Time steps back by one: the interval wraps to the largest value and the rate is 0.
        directed_rows.push_back(make_row(MODE_SAMPLE, 32'd5545, 1'b1, 1'b0, '0, '0, '0, '0));
        // Fill the ring, then overwrite its oldest entry.
        directed_rows.push_back(make_row(MODE_SAMPLE, 32'd6545, 1'b1, 1'b0, '0, '0, '0, '0));
        directed_rows.push_back(make_row(MODE_SAMPLE, 32'd7045, 1'b1, 1'b0, '0, '0, '0, '0));
        // Window reset with the beat flag set: the flag is ignored.
        directed_rows.push_back(make_row(MODE_WINDOW_RESET, 32'd10000, 1'b1, 1'b0,
                                         '0, '0, '0, '0));
        directed_rows.push_back(make_row(MODE_SAMPLE, 32'd10000, 1'b0, 1'b0, '0, '0, '0, '0));
        // Beats at exactly the window length after the start and one millisecond past it.
        directed_rows.push_back(make_row(MODE_SAMPLE, 32'd68000, 1'b1, 1'b0, '0, '0, '0, '0));
        directed_rows.push_back(make_row(MODE_SAMPLE, 32'd70000, 1'b1, 1'b0, '0, '0, '0, '0));
        directed_rows.push_back(make_row(MODE_SAMPLE, 32'd69000, 1'b1, 1'b0, '0, '0, '0, '0));
        directed_rows.push_back(make_row(MODE_SAMPLE, 32'd70001, 1'b1, 1'b0, '0, '0, '0, '0));
        // An accepted interval across the wrap of the millisecond counter.
        directed_rows.push_back(make_row(MODE_SAMPLE, 32'hFFFF_FF00, 1'b1, 1'b0,
                                         '0, '0, '0, '0));
        directed_rows.push_back(make_row(MODE_SAMPLE, 32'h0000_02E8, 1'b1, 1'b0,
                                         '0, '0, '0, '0));
        // Window restarted at the top of the counter, then a beat inside it after the wrap.
        directed_rows.push_back(make_row(MODE_WINDOW_RESET, 32'hFFFF_FFFF, 1'b0, 1'b0,
                                         '0, '0, '0, '0));
        directed_rows.push_back(make_row(MODE_SAMPLE, 32'd2244, 1'b1, 1'b0, '0, '0, '0, '0));
        directed_rows.push_back(make_row(MODE_SAMPLE, 32'hFFFF_FFFF, 1'b0, 1'b0,
                                         '0, '0, '0, '0));
        directed_rows.push_back(make_row(MODE_WINDOW_RESET, 32'd0, 1'b0, 1'b0, '0, '0, '0, '0));

        // Reset is held once, at the start.
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            offer_item(row.mode, row.now_ms, row.beat, predicted);
            pending_results.push_back(row.has_want ? row.want : predicted);
        end

        // Random phases, each with its own window length. The idle pattern starts with a
        // slow receiver, then swaps to a slow sender, and ends with both at full rate.
        for (int p = 0; p < PHASES; p++) begin
            if (p == 2) begin
                send_idle_pct = 61;
                recv_idle_pct = 12;
            end else if (p == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_window_length(window_lengths[p]);
            clock_ms = $urandom;
            repeat (PHASE_ITEMS) send_random_item();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("[heart_rate_interval_averager] OK");
        end else begin
            $display("[heart_rate_interval_averager] ERROR");
        end
        $finish;
    end

endmodule
